>>> rtl/core/bspd_pkg.sv
// Shared types and constants for the button stepped LED PWM dimmer.
// No dependencies; every other file of the block imports this package.
package bspd_pkg;

  // Fixed field and register widths.
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned DIV_W   = 10;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned INTEG_W = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Default parameter values.
  localparam int unsigned INTEGRATOR_LIMIT_DEF = 10;
  localparam int unsigned MODE_COUNT_DEF = 5;

  // Integrator thresholds: fire above, re-arm below.
  localparam logic [INTEG_W-1:0] FIRE_ABOVE  = 4'd8;
  localparam logic [INTEG_W-1:0] REARM_BELOW = 4'd2;

  // Configuration register reset values.
  localparam logic [DUTY_W-1:0] DUTY_0_RST = 8'd0;
  localparam logic [DUTY_W-1:0] DUTY_1_RST = 8'd25;
  localparam logic [DUTY_W-1:0] DUTY_2_RST = 8'd50;
  localparam logic [DUTY_W-1:0] DUTY_3_RST = 8'd75;
  localparam logic [DUTY_W-1:0] DUTY_4_RST = 8'd100;
  localparam logic [DUTY_W-1:0] PERIOD_RST = 8'd99;
  localparam logic [DIV_W-1:0]  DIVIDER_RST = 10'd9;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_0  = 3'd0,
    CFG_DUTY_1  = 3'd1,
    CFG_DUTY_2  = 3'd2,
    CFG_DUTY_3  = 3'd3,
    CFG_DUTY_4  = 3'd4,
    CFG_PERIOD  = 3'd5,
    CFG_DIVIDER = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic up_button;
    logic down_button;
  } in_t;

  typedef struct packed {
    logic              string_one_on;
    logic              string_two_on;
    logic [MODE_W-1:0] mode_now;
  } out_t;

endpackage

>>> rtl/core/bspd_btn_integ.sv
// Saturating integrator and one-shot event latch for one button.
// Depends on bspd_pkg for widths and thresholds.
module bspd_btn_integ #(
  parameter int unsigned INTEGRATOR_LIMIT = bspd_pkg::INTEGRATOR_LIMIT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic slow_tick_i,
  input  logic level_i,
  output logic fire_o
);
  import bspd_pkg::*;

  localparam logic [INTEG_W-1:0] Limit = INTEG_W'(INTEGRATOR_LIMIT);

  logic [INTEG_W-1:0] integ_q, integ_d;
  logic               latched_q, latched_d;

  always_comb begin
    integ_d = integ_q;
    if (slow_tick_i) begin
      if (level_i) begin
        if (integ_q < Limit) begin
          integ_d = integ_q + 1'b1;
        end
      end else if (integ_q != '0) begin
        integ_d = integ_q - 1'b1;
      end
    end
    // The event fires once per press; it re-arms when the count sinks low.
    fire_o    = (integ_d > FIRE_ABOVE) && !latched_q;
    latched_d = latched_q | fire_o;
    if (integ_d < REARM_BELOW) begin
      latched_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      latched_q <= 1'b0;
    end else if (step_i) begin
      integ_q   <= integ_d;
      latched_q <= latched_d;
    end
  end

endmodule

>>> rtl/core/button_stepped_led_pwm_dimmer.sv
// A result beat is valid in the cycle after its input beat is accepted.
// Throughput: one input beat per clock; the single output register is the
// only buffer, so input stall follows output stall while a result waits.
// Reset (rst_ni low, asynchronous) clears all state but out_data_q and loads
// the documented defaults into the duty, period and divider registers.
module button_stepped_led_pwm_dimmer #(
  parameter int unsigned INTEGRATOR_LIMIT = bspd_pkg::INTEGRATOR_LIMIT_DEF,
  parameter int unsigned MODE_COUNT       = bspd_pkg::MODE_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  bspd_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output bspd_pkg::out_t                       out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [bspd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bspd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import bspd_pkg::*;

  localparam logic [MODE_W-1:0] ModeTop = MODE_W'(MODE_COUNT - 1);

  // Configuration registers.
  logic [DUTY_W-1:0] duty0_q, duty1_q, duty2_q, duty3_q, duty4_q;
  logic [DUTY_W-1:0] period_q;
  logic [DIV_W-1:0]  divider_q;

  // Tick state.
  logic [DUTY_W-1:0] pwm_q, pwm_d;
  logic              sel_q;
  logic [MODE_W-1:0] mode_q, mode_d, mode_up;
  logic [DIV_W-1:0]  presc_q, presc_d;

  // Output register.
  logic out_valid_q;
  out_t out_data_q, out_data_d;

  logic accept, slow_tick, up_fire, down_fire, lit;
  logic [DUTY_W-1:0] duty;

  // A new beat is taken whenever the output register is empty or is being
  // drained in this same cycle, so beats flow back to back.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign slow_tick  = (presc_q == '0);

  // Configuration writes; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty0_q   <= DUTY_0_RST;
      duty1_q   <= DUTY_1_RST;
      duty2_q   <= DUTY_2_RST;
      duty3_q   <= DUTY_3_RST;
      duty4_q   <= DUTY_4_RST;
      period_q  <= PERIOD_RST;
      divider_q <= DIVIDER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DUTY_0:  duty0_q   <= cfg_wdata_i[DUTY_W-1:0];
        CFG_DUTY_1:  duty1_q   <= cfg_wdata_i[DUTY_W-1:0];
        CFG_DUTY_2:  duty2_q   <= cfg_wdata_i[DUTY_W-1:0];
        CFG_DUTY_3:  duty3_q   <= cfg_wdata_i[DUTY_W-1:0];
        CFG_DUTY_4:  duty4_q   <= cfg_wdata_i[DUTY_W-1:0];
        CFG_PERIOD:  period_q  <= cfg_wdata_i[DUTY_W-1:0];
        CFG_DIVIDER: divider_q <= cfg_wdata_i[DIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Duty of the current mode. Modes past the five duty registers stay dark.
  always_comb begin
    case (mode_q)
      3'd0:    duty = duty0_q;
      3'd1:    duty = duty1_q;
      3'd2:    duty = duty2_q;
      3'd3:    duty = duty3_q;
      3'd4:    duty = duty4_q;
      default: duty = '0;
    endcase
  end

  // The compare uses the counter before it advances. A period register
  // written below the counter makes it wrap to zero at once.
  assign lit   = (pwm_q < duty);
  assign pwm_d = (pwm_q < period_q) ? pwm_q + 1'b1 : '0;

  // The prescaler reloads on the slow tick; a new divider value therefore
  // takes effect only at the next reload.
  assign presc_d = slow_tick ? divider_q : presc_q - 1'b1;

  bspd_btn_integ #(
    .INTEGRATOR_LIMIT(INTEGRATOR_LIMIT)
  ) u_up (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .slow_tick_i(slow_tick),
    .level_i    (in_data_i.up_button),
    .fire_o     (up_fire)
  );

  bspd_btn_integ #(
    .INTEGRATOR_LIMIT(INTEGRATOR_LIMIT)
  ) u_down (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .slow_tick_i(slow_tick),
    .level_i    (in_data_i.down_button),
    .fire_o     (down_fire)
  );

  // The up button is checked first, then the down button, each clamped at
  // its end of the mode range.
  always_comb begin
    mode_up = mode_q;
    if (up_fire && (mode_q < ModeTop)) begin
      mode_up = mode_q + 1'b1;
    end
    mode_d = mode_up;
    if (down_fire && (mode_up != '0)) begin
      mode_d = mode_up - 1'b1;
    end
  end

  // The lit decision goes to the string picked by the select bit, which
  // toggles every tick.
  always_comb begin
    out_data_d.string_one_on = !sel_q && lit;
    out_data_d.string_two_on = sel_q && lit;
    out_data_d.mode_now      = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q   <= '0;
      sel_q   <= 1'b0;
      mode_q  <= '0;
      presc_q <= DIVIDER_RST;
    end else if (accept) begin
      pwm_q   <= pwm_d;
      sel_q   <= !sel_q;
      mode_q  <= mode_d;
      presc_q <= presc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/bspd_chk.sv
// Port-level checker for the button stepped LED PWM dimmer, bound to the top.
// Depends on bspd_pkg for the beat types.
module bspd_chk #(
  parameter int unsigned MODE_COUNT = bspd_pkg::MODE_COUNT_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input bspd_pkg::in_t                   in_data_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input bspd_pkg::out_t                  out_data_o,
  input logic                            cfg_we_i,
  input logic [bspd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [bspd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bspd_pkg::*;

  logic unused_inputs;
  assign unused_inputs = ^{in_data_i, cfg_we_i, cfg_idx_i, cfg_wdata_i};

  // A stalled result beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Every accepted input beat leaves a result behind it.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // The input side stalls only behind a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // At most one string is driven per tick, and the mode stays in range. The mode is
  // widened by one bit so that a full eight-mode range still compares correctly.
  a_result_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.string_one_on && out_data_o.string_two_on)
                    && ({1'b0, out_data_o.mode_now} < (MODE_W+1)'(MODE_COUNT)))
    else $error("result beat out of range");

endmodule

bind button_stepped_led_pwm_dimmer bspd_chk #(
  .MODE_COUNT(MODE_COUNT)
) u_bspd_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .cfg_we_i   (cfg_we_i),
  .cfg_idx_i  (cfg_idx_i),
  .cfg_wdata_i(cfg_wdata_i)
);

>>> dv/testbench.sv
// Self-checking testbench for the button stepped LED PWM dimmer.
// Depends on bspd_pkg and button_stepped_led_pwm_dimmer. A tick-accurate predictor
// runs beside the block, and every result beat is checked against it.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bspd_pkg::*;

  // The block is built with its default parameters, so the predictor uses the same values.
  localparam int unsigned INTEG_LIMIT   = INTEGRATOR_LIMIT_DEF;
  localparam int unsigned MODES         = MODE_COUNT_DEF;
  localparam int unsigned DUTY_REGS     = 5;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned PHASE_BEATS   = 240;
  localparam int unsigned LAST_BEATS    = 150;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned SHOWN_ERRORS  = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the configuration registers, starting from their reset values.
  logic [DUTY_W-1:0] duty_cfg [DUTY_REGS] =
    '{DUTY_0_RST, DUTY_1_RST, DUTY_2_RST, DUTY_3_RST, DUTY_4_RST};
  logic [DUTY_W-1:0] period_cfg = PERIOD_RST;
  logic [DIV_W-1:0]  div_cfg    = DIVIDER_RST;

  // Predictor copy of the block state.
  logic [DUTY_W-1:0]  pwm_cnt         = '0;
  logic               string_two_next = 1'b0;
  logic [MODE_W-1:0]  mode_idx        = '0;
  logic [DIV_W-1:0]   prescale        = DIVIDER_RST;
  logic [INTEG_W-1:0] up_acc          = '0;
  logic [INTEG_W-1:0] down_acc        = '0;
  logic               up_fired        = 1'b0;
  logic               down_fired      = 1'b0;

  in_t  button_feed_q [$];  // button samples waiting to be offered to the block
  out_t led_drive_q [$];    // predicted LED drive and mode, oldest first

  logic        in_took        = 1'b0;
  int unsigned bad_beats      = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asks      = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;

  button_stepped_led_pwm_dimmer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // One slow-tick step of a button integrator, saturating at both ends.
  function automatic logic [INTEG_W-1:0] integrate_step(input logic level,
                                                        input logic [INTEG_W-1:0] acc);
    if (level) begin
      return (acc < INTEG_LIMIT) ? acc + 1'b1 : acc;
    end
    return (acc != '0) ? acc - 1'b1 : acc;
  endfunction

  // Advances the predictor by one fast tick and queues the result beat that it yields.
  task automatic advance_dimmer(input in_t beat);
    logic [DUTY_W-1:0] duty;
    logic              lit;
    out_t              leds;
    // The compare uses the duty of the mode as it stood before this tick.
    duty = (mode_idx < DUTY_REGS) ? duty_cfg[mode_idx] : '0;
    lit  = (pwm_cnt < duty);
    // A period lowered below the counter makes it wrap to zero at once.
    pwm_cnt = (pwm_cnt < period_cfg) ? pwm_cnt + 1'b1 : '0;
    leds = '0;
    if (string_two_next) begin
      leds.string_two_on = lit;
    end else begin
      leds.string_one_on = lit;
    end
    string_two_next = !string_two_next;
    // A new divider value only shows at the next reload.
    if (prescale != '0) begin
      prescale = prescale - 1'b1;
    end else begin
      prescale = div_cfg;
      up_acc   = integrate_step(beat.up_button, up_acc);
      down_acc = integrate_step(beat.down_button, down_acc);
    end
    // Each button fires once per press, up first and then down.
    if (up_acc > FIRE_ABOVE && !up_fired) begin
      up_fired = 1'b1;
      if (mode_idx < MODES - 1) begin
        mode_idx = mode_idx + 1'b1;
      end
    end
    if (up_acc < REARM_BELOW) begin
      up_fired = 1'b0;
    end
    if (down_acc > FIRE_ABOVE && !down_fired) begin
      down_fired = 1'b1;
      if (mode_idx != '0) begin
        mode_idx = mode_idx - 1'b1;
      end
    end
    if (down_acc < REARM_BELOW) begin
      down_fired = 1'b0;
    end
    leds.mode_now = mode_idx;
    led_drive_q.push_back(leds);
  endtask

  // Writes one register at the next rising edge and mirrors it in the predictor.
  // Only called while nothing is in flight, so the mirror never runs ahead of a beat.
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_PERIOD: begin
        period_cfg = value[DUTY_W-1:0];
      end
      CFG_DIVIDER: begin
        div_cfg = value[DIV_W-1:0];
      end
      default: begin
        duty_cfg[idx] = value[DUTY_W-1:0];
      end
    endcase
  endtask

  // Biased toward the extremes so that zero duty and full duty come up often.
  function automatic logic [DUTY_W-1:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      return '0;
    end
    if (roll < 30) begin
      return '1;
    end
    return DUTY_W'($urandom_range(255));
  endfunction

  // Phase one runs at full duty and full period, phase two fully dark with a period of zero,
  // the last one at the slowest divider. The others draw random settings, mostly with
  // short dividers so that presses fire often.
  task automatic configure_phase(input int unsigned phase);
    logic [DUTY_W-1:0] duty;
    logic [DUTY_W-1:0] period;
    for (int i = 0; i < DUTY_REGS; i++) begin
      if (phase == 1) begin
        duty = '1;
      end else if (phase == 2) begin
        duty = '0;
      end else begin
        duty = pick_byte();
      end
      cfg_write(cfg_idx_e'(i), CFG_DATA_W'(duty));
    end
    period = (phase == 1) ? 8'hFF : (phase == 2) ? 8'h00 : pick_byte();
    cfg_write(CFG_PERIOD, CFG_DATA_W'(period));
    cfg_write(CFG_DIVIDER, (phase == RANDOM_PHASES - 1) ? 10'h3FF :
                           10'($urandom_range(3)));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Fills the feed with button activity shaped like real use: presses held long enough to
  // fire (some too short), releases long enough to re-arm (some too short), and bursts
  // of contact bounce. Run lengths scale with the slow tick so that presses still count.
  task automatic queue_button_runs(input int unsigned count);
    int unsigned left;
    int unsigned run;
    int unsigned roll;
    int unsigned slow;
    in_t         level;
    left = count;
    while (left != 0) begin
      slow = int'(div_cfg) + 1;
      roll = $urandom_range(99);
      level = '0;
      if (roll < 40) begin
        level.up_button   = 1'($urandom_range(1));
        level.down_button = !level.up_button;
        if ($urandom_range(9) == 0) begin
          level = '1;
        end
        run = $urandom_range(2, 14) * slow;
      end else if (roll < 80) begin
        run = $urandom_range(2, 12) * slow;
      end else begin
        run = $urandom_range(1, 8);
      end
      for (int k = 0; k < run && left != 0; k++) begin
        if (roll >= 80) begin
          level = in_t'(2'($urandom_range(3)));
        end
        button_feed_q.push_back(level);
        left--;
      end
    end
  endtask

  // Polled at the rising edge, where the driver's valid is settled: no pending sample, no
  // beat on offer and no result outstanding means the block is idle.
  task automatic wait_drained();
    while (button_feed_q.size() != 0 || in_valid || led_drive_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed start at the reset settings: mode zero has zero duty, so both strings stay
    // dark while all four button combinations go by.
    for (int i = 0; i < 12; i++) begin
      button_feed_q.push_back(in_t'(2'(i)));
    end
    wait_drained();

    // The period drops below the running counter, which wraps at once, and the duty
    // exceeds the period so the active string is always lit. The divider change waits for
    // the reload that is still pending.
    cfg_write(CFG_DUTY_0, 10'd200);
    cfg_write(CFG_PERIOD, 10'd2);
    cfg_write(CFG_DIVIDER, 10'd0);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    for (int i = 0; i < 12; i++) begin
      button_feed_q.push_back((i < 6) ? in_t'(2'b10) : in_t'(2'b01));
    end

    // Random phases. The idle pattern rotates through none, sender only, receiver only and
    // both, and the quiet phases also get one long receiver hold-off while the sender keeps
    // offering, so the output register fills and the input stalls.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      configure_phase(phase);
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      queue_button_runs((phase == RANDOM_PHASES - 1) ? LAST_BEATS : PHASE_BEATS);
      if (phase % 4 == 0) begin
        hold_asks++;
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (bad_beats == 0 && led_drive_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Driver: a beat stays on offer until it is taken. Whether the next one follows at once
  // or after a gap is decided without looking at the stall.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (button_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= button_feed_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here in cycles, started once per request.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  always @(negedge clk_i) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: checks each result beat against the oldest prediction, then predicts the
  // input beat taken at the same edge.
  always @(posedge clk_i) begin
    out_t got;
    out_t want;
    in_took <= in_valid && !in_stall;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (led_drive_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= SHOWN_ERRORS) begin
            $display("unexpected result beat: one %b two %b mode %0d",
                     got.string_one_on, got.string_two_on, got.mode_now);
          end
        end else begin
          want = led_drive_q.pop_front();
          if (got.string_one_on !== want.string_one_on ||
              got.string_two_on !== want.string_two_on ||
              got.mode_now !== want.mode_now) begin
            bad_beats++;
            if (bad_beats <= SHOWN_ERRORS) begin
              $display({"result mismatch: one exp %b got %b, two exp %b got %b, ",
                        "mode exp %0d got %0d"},
                       want.string_one_on, got.string_one_on,
                       want.string_two_on, got.string_two_on,
                       want.mode_now, got.mode_now);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_dimmer(in_data);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

>>> button_stepped_led_pwm_dimmer.f
rtl/core/bspd_pkg.sv
rtl/core/bspd_btn_integ.sv
rtl/core/button_stepped_led_pwm_dimmer.sv
rtl/core/bspd_chk.sv
dv/testbench.sv
